// ----- src/string_keyed_direct_slot_table_defines.svh -----
// assertion macros for the string keyed direct slot table
`ifndef STRING_KEYED_DIRECT_SLOT_TABLE_DEFINES_SVH
`define STRING_KEYED_DIRECT_SLOT_TABLE_DEFINES_SVH

// same-cycle implication on clk_i, off during reset
`define SDST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk_i, off during reset
`define SDST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/sdst_pkg.sv -----
// shared types and constants of the string keyed direct slot table
package sdst_pkg;

  localparam int unsigned HASH_W          = 64;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned CFG_W           = 9;
  localparam int unsigned IDX_W           = 8;
  localparam int unsigned DATA_W          = 64;
  localparam int unsigned SLOTS_DEF       = 256;
  localparam int unsigned VALUE_BYTES_DEF = 8;
  localparam int unsigned DIV_STEP        = 4;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam logic [CFG_W-1:0] SLOT_COUNT_RST = 9'd256;

  typedef enum logic {
    OP_SET = 1'b0,
    OP_GET = 1'b1
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [HASH_W-1:0] hash;
    logic [DATA_W-1:0] wval;
  } key_word_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_DIV,
    BK_READ,
    BK_OUT
  } back_state_e;

endpackage

// ----- src/sdst_front.sv -----
// front end: accepts key bytes, runs the hash and queues finished keys
module sdst_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          operation_i,
  input  logic [sdst_pkg::BYTE_W-1:0]   key_byte_i,
  input  logic                          key_last_i,
  input  logic [sdst_pkg::DATA_W-1:0]   write_value_i,
  input  logic                          busy_i,
  input  logic                          full_i,
  output logic                          push_o,
  output sdst_pkg::key_word_t           push_word_o
);

  logic [sdst_pkg::HASH_W-1:0] hash_q, hash_d, hash_next;
  logic                        accept;

  // times 97 as shift-add, plus the byte
  assign hash_next = (hash_q << 6) + (hash_q << 5) + hash_q
                   + sdst_pkg::HASH_W'(key_byte_i);

  assign in_stall_o = busy_i | full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign push_o     = accept & key_last_i;

  assign push_word_o.op   = sdst_pkg::op_e'(operation_i);
  assign push_word_o.hash = hash_next;
  assign push_word_o.wval = write_value_i;

  always_comb begin
    hash_d = hash_q;
    if (accept) begin
      hash_d = key_last_i ? '0 : hash_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
    end else begin
      hash_q <= hash_d;
    end
  end

endmodule

// ----- src/sdst_fifo.sv -----
// short queue of finished keys between front and back
module sdst_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sdst_pkg::key_word_t push_word_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output sdst_pkg::key_word_t pop_word_o
);

  localparam int unsigned PW = $clog2(sdst_pkg::QUEUE_DEPTH);
  localparam int unsigned CNTW = $clog2(sdst_pkg::QUEUE_DEPTH + 1);

  sdst_pkg::key_word_t mem_q [sdst_pkg::QUEUE_DEPTH];
  logic [PW-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [CNTW-1:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o     = (cnt_q == CNTW'(sdst_pkg::QUEUE_DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_word_o = mem_q[rd_q];
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(sdst_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(sdst_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_word_i;
    end
  end

endmodule

// ----- src/sdst_ram.sv -----
// generic single write port ram with registered read
module sdst_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  assign rdata_o = rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

endmodule

// ----- src/sdst_back.sv -----
// back end: clears the slots after reset, hash modulo slot count, slot access and result register
module sdst_back #(
  parameter int unsigned SLOTS       = sdst_pkg::SLOTS_DEF,
  parameter int unsigned VALUE_BYTES = sdst_pkg::VALUE_BYTES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [sdst_pkg::CFG_W-1:0]  slot_count_i,
  input  logic                        q_valid_i,
  input  sdst_pkg::key_word_t         q_word_i,
  output logic                        q_pop_o,
  output logic                        busy_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [sdst_pkg::IDX_W-1:0]  slot_index_o,
  output logic [sdst_pkg::DATA_W-1:0] read_value_o
);

  localparam int unsigned AW    = $clog2(SLOTS);
  localparam int unsigned CW    = $clog2(SLOTS + 1);
  localparam int unsigned VW    = VALUE_BYTES * 8;
  localparam int unsigned ITERS = sdst_pkg::HASH_W / sdst_pkg::DIV_STEP;
  localparam int unsigned ITW   = $clog2(ITERS);

  sdst_pkg::back_state_e state_q, state_d;

  logic [AW-1:0]                 clr_q;
  logic [ITW-1:0]                cnt_q;
  logic [sdst_pkg::HASH_W-1:0]   dvd_q;
  logic [CW-1:0]                 rem_q, div_q, rem_step, eff;
  sdst_pkg::op_e                 op_q;
  logic [VW-1:0]                 wval_q;
  logic                          out_valid_q;
  logic [sdst_pkg::IDX_W-1:0]    slot_q;
  logic [sdst_pkg::DATA_W-1:0]   value_q;
  logic [31:0]                   sc_ext, eff_ext;
  logic                          out_free, load_out;
  logic                          ram_we, ram_re;
  logic [AW-1:0]                 ram_waddr, slot;
  logic [VW-1:0]                 ram_wdata, ram_rdata;

  assign out_free     = ~out_valid_q | ~out_stall_i;
  assign slot         = rem_q[AW-1:0];
  assign out_valid_o  = out_valid_q;
  assign slot_index_o = slot_q;
  assign read_value_o = value_q;

  // effective divisor: zero means one, saturate at table size
  always_comb begin
    sc_ext  = 32'(slot_count_i);
    eff_ext = sc_ext;
    if (sc_ext == 32'd0) begin
      eff_ext = 32'd1;
    end else if (sc_ext > SLOTS) begin
      eff_ext = 32'(SLOTS);
    end
    eff = CW'(eff_ext);
  end

  // restoring remainder, several dividend bits per cycle
  always_comb begin
    logic [CW-1:0] r;
    logic [CW:0]   t;
    r = rem_q;
    for (int i = 0; i < sdst_pkg::DIV_STEP; i++) begin
      t = {r, dvd_q[sdst_pkg::HASH_W-1-i]};
      if (t >= {1'b0, div_q}) begin
        r = CW'(t - {1'b0, div_q});
      end else begin
        r = t[CW-1:0];
      end
    end
    rem_step = r;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sdst_pkg::BK_CLEAR: begin
        if (clr_q == AW'(SLOTS - 1)) state_d = sdst_pkg::BK_IDLE;
      end
      sdst_pkg::BK_IDLE: begin
        if (q_valid_i) state_d = sdst_pkg::BK_DIV;
      end
      sdst_pkg::BK_DIV: begin
        if (cnt_q == ITW'(ITERS - 1)) state_d = sdst_pkg::BK_READ;
      end
      sdst_pkg::BK_READ: begin
        state_d = sdst_pkg::BK_OUT;
      end
      sdst_pkg::BK_OUT: begin
        if (out_free) state_d = sdst_pkg::BK_IDLE;
      end
      default: begin
        state_d = sdst_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    busy_o    = 1'b0;
    q_pop_o   = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = slot;
    ram_wdata = wval_q;
    load_out  = 1'b0;
    unique case (state_q)
      sdst_pkg::BK_CLEAR: begin
        busy_o    = 1'b1;
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      sdst_pkg::BK_IDLE: begin
        q_pop_o = q_valid_i;
      end
      sdst_pkg::BK_DIV: begin
      end
      sdst_pkg::BK_READ: begin
        ram_re = 1'b1;
      end
      sdst_pkg::BK_OUT: begin
        load_out = out_free;
        ram_we   = out_free & (op_q == sdst_pkg::OP_SET);
      end
      default: begin
      end
    endcase
  end

  sdst_ram #(
    .WIDTH (VW),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (slot),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sdst_pkg::BK_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= load_out | (out_valid_q & out_stall_i);
      if (state_q == sdst_pkg::BK_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (q_pop_o) begin
        cnt_q <= '0;
      end else if (state_q == sdst_pkg::BK_DIV) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      dvd_q  <= q_word_i.hash;
      rem_q  <= '0;
      div_q  <= eff;
      op_q   <= q_word_i.op;
      wval_q <= q_word_i.wval[VW-1:0];
    end else if (state_q == sdst_pkg::BK_DIV) begin
      dvd_q <= dvd_q << sdst_pkg::DIV_STEP;
      rem_q <= rem_step;
    end
    if (load_out) begin
      slot_q  <= sdst_pkg::IDX_W'(slot);
      value_q <= (op_q == sdst_pkg::OP_SET) ? sdst_pkg::DATA_W'(wval_q)
                                            : sdst_pkg::DATA_W'(ram_rdata);
    end
  end

endmodule

// ----- src/string_keyed_direct_slot_table.sv -----
// top level of the string keyed direct slot table
// A key streams in one byte per word, the last byte flagged, and the hash front
// end takes one byte per cycle while the input is not stalled. A finished key
// is queued (two deep) for the back end, which pops the key, reduces the 64-bit
// hash modulo the slot count four bits per cycle, reads the slot, then writes
// back and loads the result, waiting there while the output is stalled; it
// takes no new key before that. Keys arriving faster than the back end finishes
// them fill the queue, and a full queue stalls the input. Only the last byte of
// a key gives a result word. After reset the slot store is zeroed, one entry
// per cycle, during which input is stalled.
module string_keyed_direct_slot_table #(
  parameter int unsigned SLOTS       = sdst_pkg::SLOTS_DEF,
  parameter int unsigned VALUE_BYTES = sdst_pkg::VALUE_BYTES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sdst_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        operation_i,
  input  logic [sdst_pkg::BYTE_W-1:0] key_byte_i,
  input  logic                        key_last_i,
  input  logic [sdst_pkg::DATA_W-1:0] write_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [sdst_pkg::IDX_W-1:0]  slot_index_o,
  output logic [sdst_pkg::DATA_W-1:0] read_value_o
);

  logic [sdst_pkg::CFG_W-1:0] slot_count_q;
  logic                       busy, full, push, q_valid, q_pop;
  sdst_pkg::key_word_t        push_word, q_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= sdst_pkg::SLOT_COUNT_RST;
    end else if (cfg_we_i) begin
      slot_count_q <= cfg_wdata_i;
    end
  end

  sdst_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .key_byte_i    (key_byte_i),
    .key_last_i    (key_last_i),
    .write_value_i (write_value_i),
    .busy_i        (busy),
    .full_i        (full),
    .push_o        (push),
    .push_word_o   (push_word)
  );

  sdst_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (push_word),
    .full_o      (full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_word_o  (q_word)
  );

  sdst_back #(
    .SLOTS       (SLOTS),
    .VALUE_BYTES (VALUE_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .slot_count_i (slot_count_q),
    .q_valid_i    (q_valid),
    .q_word_i     (q_word),
    .q_pop_o      (q_pop),
    .busy_o       (busy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .slot_index_o (slot_index_o),
    .read_value_o (read_value_o)
  );

endmodule

// ----- src/sdst_checker.sv -----
// port-level checks of the string keyed direct slot table
`include "string_keyed_direct_slot_table_defines.svh"

module sdst_checker #(
  parameter int unsigned SLOTS       = sdst_pkg::SLOTS_DEF,
  parameter int unsigned VALUE_BYTES = sdst_pkg::VALUE_BYTES_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_stall_i,
  input logic [sdst_pkg::IDX_W-1:0]  slot_index_i,
  input logic [sdst_pkg::DATA_W-1:0] read_value_i
);

  localparam int unsigned VW = VALUE_BYTES * 8;

  logic                                         stalled;
  logic [sdst_pkg::IDX_W+sdst_pkg::DATA_W-1:0] res_word;

  assign stalled  = out_valid_i && out_stall_i;
  assign res_word = {slot_index_i, read_value_i};

  `SDST_ASSERT_NXT(a_out_hold, stalled, out_valid_i && $stable(res_word), "stalled word changed")

  `SDST_ASSERT_IMP(a_slot_range, out_valid_i, 32'(slot_index_i) < SLOTS, "slot index beyond table")

  `SDST_ASSERT_IMP(a_value_width, out_valid_i, (read_value_i >> VW) == '0, "value too wide")

endmodule

bind string_keyed_direct_slot_table sdst_checker #(
  .SLOTS       (SLOTS),
  .VALUE_BYTES (VALUE_BYTES)
) u_sdst_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .slot_index_i (slot_index_o),
  .read_value_i (read_value_o)
);
